>>> hdl/boic_pkg.sv
// Shared types, codes and helpers for the bond order ice classifier.
package boic_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_BOND   = 2'd1;
  localparam logic [1:0] KIND_SKIP   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // structure codes
  localparam logic [2:0] ST_OTHER = 3'd0;
  localparam logic [2:0] ST_HEX   = 3'd1;
  localparam logic [2:0] ST_CUBIC = 3'd2;
  localparam logic [2:0] ST_IICE  = 3'd3;
  localparam logic [2:0] ST_HYD   = 3'd4;
  localparam logic [2:0] ST_IHYD  = 3'd5;

  // register indexes
  localparam logic [1:0] REG_ECL_LOW  = 2'd0;
  localparam logic [1:0] REG_ECL_HIGH = 2'd1;
  localparam logic [1:0] REG_STAG     = 2'd2;

  localparam int TERMS    = 7;
  localparam int PIDX_W   = 10;
  localparam int TERM_W   = 3;
  localparam int THR_W    = 16;
  localparam int DIG_W    = 8;
  localparam int SCALE_SH = 30;
  localparam int BASE_W   = 13;

  typedef struct packed {
    logic signed [THR_W-1:0] ecl_low;
    logic signed [THR_W-1:0] ecl_high;
    logic signed [THR_W-1:0] stag;
  } thr_t;

  typedef struct packed {
    logic done;
    logic eclipsed;
    logic staggered;
  } bond_res_t;

  // first term address of a particle: particle * 7
  function automatic logic [BASE_W-1:0] term_base(input logic [PIDX_W-1:0] p);
    term_base = {p, 3'b000} - {3'b000, p};
  endfunction

endpackage

>>> hdl/boic_qmem.sv
// Term memory: one write port, two registered read ports.
module boic_qmem import boic_pkg::*; #(
  parameter int DEPTH = 7168,
  parameter int AW    = 13,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hdl/boic_bigmul.sv
// Iterative wide multiplier: one 8-bit digit of b per cycle, MSB digit first.
module boic_bigmul import boic_pkg::*; #(
  parameter int A_W = 100,
  parameter int BD  = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [A_W-1:0]            a,
  input  logic [DIG_W*BD-1:0]       b,
  output logic                      done,
  output logic [A_W+DIG_W*BD-1:0]   product
);

  localparam int BBW = DIG_W * BD;
  localparam int PW  = A_W + BBW;
  localparam int CW  = $clog2(BD + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [A_W-1:0] a_r;
  logic [BBW-1:0] b_r;
  logic [PW-1:0]  acc_r;
  logic [A_W+DIG_W-1:0] pp;

  // partial product of the current digit
  assign pp = (A_W+DIG_W)'(a_r) * (A_W+DIG_W)'(b_r[BBW-1 -: DIG_W]);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse after the last digit step
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BD);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << DIG_W) + PW'(pp);
      b_r   <= b_r << DIG_W;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

>>> hdl/boic_bond.sv
// Bond engine: reads both term sets, accumulates dot and norms, tests thresholds.
module boic_bond import boic_pkg::*; #(
  parameter int MAX_PARTICLES = 1024,
  parameter int Q_WIDTH       = 24,
  parameter int MEM_AW        = 13
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [PIDX_W-1:0]      part_a,
  input  logic [PIDX_W-1:0]      part_b,
  input  thr_t                   thr,
  output logic                   rd_en,
  output logic [MEM_AW-1:0]      raddr_a,
  output logic [MEM_AW-1:0]      raddr_b,
  input  logic [2*Q_WIDTH-1:0]   rdata_a,
  input  logic [2*Q_WIDTH-1:0]   rdata_b,
  output bond_res_t              res
);

  localparam int PW   = 2 * Q_WIDTH;
  localparam int NW   = PW + 2;
  localparam int DTW  = NW + 1;
  localparam int BW   = (NW > 32) ? NW : 32;
  localparam int BD   = (BW + DIG_W - 1) / DIG_W;
  localparam int BBW  = DIG_W * BD;
  localparam int AWID = 2 * NW;
  localparam int PRW  = AWID + BBW;
  localparam int CMW  = PRW + SCALE_SH;

  localparam logic [1:0] DST_DOT = 2'd0;
  localparam logic [1:0] DST_N1  = 2'd1;
  localparam logic [1:0] DST_N2  = 2'd2;

  typedef enum logic [3:0] {
    E_IDLE, E_READ, E_MUL, E_DRAIN, E_NP, E_WNP, E_ND, E_WND, E_TH, E_WTH, E_DONE
  } est_t;

  typedef enum logic [1:0] {CMP_LT, CMP_EQ, CMP_GT} cmp_t;

  est_t                   state_r;
  logic [2:0]             m_r;
  logic [2:0]             ph_r;
  logic [1:0]             k_r;
  logic [MEM_AW-1:0]      base_a_r;
  logic [MEM_AW-1:0]      base_b_r;
  logic                   oob_a_r;
  logic                   oob_b_r;
  logic                   pvld_r;
  logic [1:0]             pdst_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [DTW-1:0]  dot_r;
  logic [NW-1:0]          n1_r;
  logic [NW-1:0]          n2_r;
  logic [AWID-1:0]        p_r;
  logic [AWID-1:0]        d2_r;
  cmp_t                   cmp_lo_r;
  cmp_t                   cmp_hi_r;
  cmp_t                   cmp_st_r;

  logic signed [Q_WIDTH-1:0] ar, ai, br, bi, mx, my;
  logic [1:0]             dst;
  logic [NW-1:0]          dmag;
  logic signed [THR_W-1:0] tsel;
  logic [THR_W-1:0]       tmag;
  logic [31:0]            tt;
  logic                   mul_start;
  logic [AWID-1:0]        mul_a;
  logic [BBW-1:0]         mul_b;
  logic                   mul_done;
  logic [PRW-1:0]         mul_prod;
  logic [CMW-1:0]         xv;
  logic [CMW-1:0]         yv;
  logic                   dpos, dneg, tpos, tneg;
  cmp_t                   cmp_now;
  logic                   pzero;

  // operands, out-of-range endpoints read as zero
  assign ar = oob_a_r ? '0 : rdata_a[Q_WIDTH-1:0];
  assign ai = oob_a_r ? '0 : rdata_a[PW-1:Q_WIDTH];
  assign br = oob_b_r ? '0 : rdata_b[Q_WIDTH-1:0];
  assign bi = oob_b_r ? '0 : rdata_b[PW-1:Q_WIDTH];

  // product phase selection
  always_comb begin
    case (ph_r)
      3'd0: begin mx = ar; my = br; dst = DST_DOT; end
      3'd1: begin mx = ai; my = bi; dst = DST_DOT; end
      3'd2: begin mx = ar; my = ar; dst = DST_N1; end
      3'd3: begin mx = ai; my = ai; dst = DST_N1; end
      3'd4: begin mx = br; my = br; dst = DST_N2; end
      default: begin mx = bi; my = bi; dst = DST_N2; end
    endcase
  end

  assign rd_en   = (state_r == E_READ);
  assign raddr_a = base_a_r + MEM_AW'(m_r);
  assign raddr_b = base_b_r + MEM_AW'(m_r);

  // dot magnitude and selected threshold
  assign dmag = dot_r[DTW-1] ? NW'(-dot_r) : NW'(dot_r);

  always_comb begin
    case (k_r)
      2'd0:    tsel = thr.ecl_low;
      2'd1:    tsel = thr.ecl_high;
      default: tsel = thr.stag;
    endcase
  end

  assign tmag = tsel[THR_W-1] ? THR_W'(-tsel) : THR_W'(tsel);
  assign tt   = 32'(tmag) * 32'(tmag);

  // wide multiplier operands
  assign mul_start = (state_r == E_NP) || (state_r == E_ND) || (state_r == E_TH);

  always_comb begin
    case (state_r)
      E_NP: begin
        mul_a = AWID'(n1_r);
        mul_b = BBW'(n2_r);
      end
      E_ND: begin
        mul_a = AWID'(dmag);
        mul_b = BBW'(dmag);
      end
      default: begin
        mul_a = p_r;
        mul_b = BBW'(tt);
      end
    endcase
  end

  boic_bigmul #(.A_W(AWID), .BD(BD)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // signed compare of dot/sqrt(p) against t/2^15 via squares
  assign dpos = (dot_r > 0);
  assign dneg = dot_r[DTW-1];
  assign tpos = (tsel > 0);
  assign tneg = tsel[THR_W-1];
  assign xv   = CMW'(d2_r) << SCALE_SH;
  assign yv   = CMW'(mul_prod);

  always_comb begin
    if ((dpos != tpos) || (dneg != tneg)) begin
      cmp_now = (dpos || (!dneg && tneg)) ? CMP_GT : CMP_LT;
    end else if (!dpos && !dneg) begin
      cmp_now = CMP_EQ;
    end else if (xv == yv) begin
      cmp_now = CMP_EQ;
    end else if ((xv > yv) != dneg) begin
      cmp_now = CMP_GT;
    end else begin
      cmp_now = CMP_LT;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      m_r     <= '0;
      ph_r    <= '0;
      k_r     <= '0;
      pvld_r  <= 1'b0;
    end else begin
      pvld_r <= (state_r == E_MUL);
      case (state_r)
        E_IDLE: begin
          if (start) begin
            m_r     <= '0;
            state_r <= E_READ;
          end
        end
        E_READ: begin
          ph_r    <= '0;
          state_r <= E_MUL;
        end
        E_MUL: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd5) begin
            if (m_r == 3'(TERMS - 1)) begin
              state_r <= E_DRAIN;
            end else begin
              m_r     <= m_r + 1'b1;
              state_r <= E_READ;
            end
          end
        end
        E_DRAIN: state_r <= E_NP;
        E_NP:    state_r <= E_WNP;
        E_WNP: begin
          if (mul_done) begin
            state_r <= E_ND;
          end
        end
        E_ND:    state_r <= E_WND;
        E_WND: begin
          if (mul_done) begin
            k_r     <= '0;
            state_r <= E_TH;
          end
        end
        E_TH:    state_r <= E_WTH;
        E_WTH: begin
          if (mul_done) begin
            k_r     <= k_r + 1'b1;
            state_r <= (k_r == 2'd2) ? E_DONE : E_TH;
          end
        end
        E_DONE:  state_r <= E_IDLE;
        default: state_r <= E_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == E_IDLE && start) begin
      base_a_r <= MEM_AW'(term_base(part_a));
      base_b_r <= MEM_AW'(term_base(part_b));
      oob_a_r  <= (32'(part_a) >= MAX_PARTICLES);
      oob_b_r  <= (32'(part_b) >= MAX_PARTICLES);
      dot_r    <= '0;
      n1_r     <= '0;
      n2_r     <= '0;
    end else if (pvld_r) begin
      case (pdst_r)
        DST_DOT: dot_r <= dot_r + DTW'(prod_r);
        DST_N1:  n1_r  <= n1_r + NW'($unsigned(prod_r));
        default: n2_r  <= n2_r + NW'($unsigned(prod_r));
      endcase
    end
    if (state_r == E_MUL) begin
      prod_r <= mx * my;
      pdst_r <= dst;
    end
    if (state_r == E_WNP && mul_done) begin
      p_r <= mul_prod[AWID-1:0];
    end
    if (state_r == E_WND && mul_done) begin
      d2_r <= mul_prod[AWID-1:0];
    end
    if (state_r == E_WTH && mul_done) begin
      case (k_r)
        2'd0:    cmp_lo_r <= cmp_now;
        2'd1:    cmp_hi_r <= cmp_now;
        default: cmp_st_r <= cmp_now;
      endcase
    end
  end

  // a zero norm product makes the bond neither eclipsed nor staggered
  assign pzero         = (p_r == '0);
  assign res.done      = (state_r == E_DONE);
  assign res.eclipsed  = !pzero && (cmp_lo_r == CMP_GT) && (cmp_hi_r == CMP_LT);
  assign res.staggered = !pzero && (cmp_st_r == CMP_LT);

endmodule

>>> hdl/bond_order_ice_classifier_core.sv
// Top level: handshakes, config registers, bond counters and classification.
//
//  channel | ports                                  | moves
//  in      | in_valid/in_ready, in_* fields         | load, bond or skip item
//  out     | out_valid/out_ready, out_* fields      | one classified particle
//  cfg     | psel/penable/pwrite/paddr/pwdata/...   | threshold registers
//
// Load, skip and ignored items complete when accepted. A bond runs seven
// term reads sharing one multiplier over six products, then five passes of
// the digit-serial wide multiplier over BD = ceil(max(2*Q_WIDTH+2, 32)/8)
// digits (7 at Q_WIDTH 24). One bond runs at a time. Reset is synchronous,
// active low; term memory contents are not cleared. A finished result waits
// in the output register; input stalls while a bond runs and while that
// register is full and not read.
module bond_order_ice_classifier_core import boic_pkg::*; #(
  parameter int MAX_PARTICLES = 1024,
  parameter int Q_WIDTH       = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_kind,
  input  logic [PIDX_W-1:0]         in_particle,
  input  logic [PIDX_W-1:0]         in_neighbor,
  input  logic [TERM_W-1:0]         in_term_index,
  input  logic signed [Q_WIDTH-1:0] in_q_real,
  input  logic signed [Q_WIDTH-1:0] in_q_imag,
  input  logic                      in_last_bond,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_structure,
  output logic [PIDX_W-1:0]         out_particle_out,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int DEPTH  = MAX_PARTICLES * TERMS;
  localparam int MEM_AW = $clog2(DEPTH);

  typedef enum logic [1:0] {T_IDLE, T_BUSY, T_FIN} tst_t;

  tst_t              state_r;
  thr_t              thr_r;
  logic [2:0]        ecl_cnt_r;
  logic [2:0]        stag_cnt_r;
  logic [2:0]        bond_cnt_r;
  logic              last_r;
  logic [PIDX_W-1:0] part_r;
  logic              out_valid_r;
  logic [2:0]        out_structure_r;
  logic [PIDX_W-1:0] out_particle_r;

  logic              acc;
  logic              ofree;
  logic              out_set;
  logic              in_range;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic              rd_en;
  logic [MEM_AW-1:0] raddr_a;
  logic [MEM_AW-1:0] raddr_b;
  logic [2*Q_WIDTH-1:0] rdata_a;
  logic [2*Q_WIDTH-1:0] rdata_b;
  logic              bond_start;
  bond_res_t         bres;
  logic              cfg_we;

  function automatic logic [2:0] classify(input logic [2:0] bc, input logic [2:0] e,
                                          input logic [2:0] s);
    if (bc != 3'd4)                   classify = ST_OTHER;
    else if (e == 3'd4)               classify = ST_HYD;
    else if (e == 3'd3)               classify = ST_IHYD;
    else if (s == 3'd4)               classify = ST_CUBIC;
    else if (s == 3'd3 && e == 3'd1)  classify = ST_HEX;
    else if (s == 3'd3 && e == 3'd0)  classify = ST_IICE;
    else if (s == 3'd2)               classify = ST_IICE;
    else                              classify = ST_OTHER;
  endfunction

  // handshakes
  assign ofree    = !out_valid_r || out_ready;
  assign in_ready = (state_r == T_IDLE) && ofree;
  assign acc      = in_valid && in_ready;

  // a new result enters the output register
  assign out_set  = (acc && (in_kind == KIND_SKIP)) || ((state_r == T_FIN) && ofree);

  // term loads
  assign in_range  = (32'(in_particle) < MAX_PARTICLES) && (32'(in_term_index) < TERMS);
  assign mem_we    = acc && (in_kind == KIND_LOAD) && in_range;
  assign mem_waddr = MEM_AW'(term_base(in_particle)) + MEM_AW'(in_term_index);

  boic_qmem #(.DEPTH(DEPTH), .AW(MEM_AW), .DW(2*Q_WIDTH)) u_qmem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   ({in_q_imag, in_q_real}),
    .re      (rd_en),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign bond_start = acc && (in_kind == KIND_BOND);

  boic_bond #(.MAX_PARTICLES(MAX_PARTICLES), .Q_WIDTH(Q_WIDTH), .MEM_AW(MEM_AW)) u_bond (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (bond_start),
    .part_a  (in_particle),
    .part_b  (in_neighbor),
    .thr     (thr_r),
    .rd_en   (rd_en),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .res     (bres)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_ECL_LOW:  prdata = {16'd0, thr_r.ecl_low};
      REG_ECL_HIGH: prdata = {16'd0, thr_r.ecl_high};
      REG_STAG:     prdata = {16'd0, thr_r.stag};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.ecl_low  <= -16'sd11469;
      thr_r.ecl_high <= 16'sd8192;
      thr_r.stag     <= -16'sd26214;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ECL_LOW:  thr_r.ecl_low  <= pwdata[THR_W-1:0];
        REG_ECL_HIGH: thr_r.ecl_high <= pwdata[THR_W-1:0];
        REG_STAG:     thr_r.stag     <= pwdata[THR_W-1:0];
        default:      ;
      endcase
    end
  end

  // control, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      ecl_cnt_r   <= '0;
      stag_cnt_r  <= '0;
      bond_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (acc) begin
            case (in_kind)
              KIND_BOND: begin
                part_r  <= in_particle;
                last_r  <= in_last_bond;
                state_r <= T_BUSY;
              end
              KIND_SKIP: begin
                out_structure_r <= ST_OTHER;
                out_particle_r  <= in_particle;
              end
              default: ;
            endcase
          end
        end
        T_BUSY: begin
          if (bres.done) begin
            if (bond_cnt_r != 3'd5) bond_cnt_r <= bond_cnt_r + 1'b1;
            if (bres.eclipsed && ecl_cnt_r != 3'd7) ecl_cnt_r <= ecl_cnt_r + 1'b1;
            if (bres.staggered && stag_cnt_r != 3'd7) stag_cnt_r <= stag_cnt_r + 1'b1;
            state_r <= last_r ? T_FIN : T_IDLE;
          end
        end
        T_FIN: begin
          if (ofree) begin
            out_structure_r <= classify(bond_cnt_r, ecl_cnt_r, stag_cnt_r);
            out_particle_r  <= part_r;
            ecl_cnt_r       <= '0;
            stag_cnt_r      <= '0;
            bond_cnt_r      <= '0;
            state_r         <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_structure    = out_structure_r;
  assign out_particle_out = out_particle_r;

endmodule
